// File: rtl/core/sharp_pkg.sv
// ----------------------------------------------------------------------------
// sharp_pkg
// Shared types and constants of the 3x3 sharpen convolution core.
// ----------------------------------------------------------------------------
package sharp_pkg;

	localparam int PIX_W   = 8;
	localparam int ROW_W   = 12;
	localparam int IMGW_W  = 11;
	localparam int IMGH_W  = 13;
	localparam int OFS_W   = 8;
	localparam int WGT_W   = 4;
	localparam int TAPS    = 9;
	localparam int KERN_W  = TAPS * WGT_W;
	localparam int CFG_DATA_W = KERN_W;

	localparam int HEIGHT_MAX = 4096;
	localparam int GEOM_MIN   = 3;

	localparam logic [IMGW_W-1:0] WIDTH_RST   = IMGW_W'(200);
	localparam logic [IMGH_W-1:0] HEIGHT_RST  = IMGH_W'(200);
	localparam logic [OFS_W-1:0]  OFFSET_RST  = OFS_W'(128);
	localparam logic [KERN_W-1:0] WEIGHTS_RST = 36'h0_F0F5_F0F0;

	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 neighborhood, row-major, tap 0 is the top-left pixel
	typedef pix_t [TAPS-1:0] nbhd_t;

	// one line store word: row r-2 and row r-1 of the same column
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_pair_t;

	typedef enum logic [1:0] {
		CFG_WIDTH   = 2'd0,
		CFG_HEIGHT  = 2'd1,
		CFG_OFFSET  = 2'd2,
		CFG_WEIGHTS = 2'd3
	} cfg_idx_t;

endpackage

// File: rtl/core/sharp_line_buf.sv
// ----------------------------------------------------------------------------
// sharp_line_buf
// Dual line store: one word per column holding the two rows above.
// ----------------------------------------------------------------------------
module sharp_line_buf import sharp_pkg::*; #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output line_pair_t        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  line_pair_t        wr_data
);

	line_pair_t mem [DEPTH];
	line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/sharp_mac.sv
// ----------------------------------------------------------------------------
// sharp_mac
// Nine-tap weighted sum with offset and clamp to 0..255.
// ----------------------------------------------------------------------------
module sharp_mac import sharp_pkg::*; (
	input  nbhd_t              nbhd,
	input  logic [KERN_W-1:0]  weights,
	input  logic [OFS_W-1:0]   offset,
	output pix_t               result
);

	// 9 x (9-bit x 4-bit signed) plus the offset fits in 16 bits; the sum is 18 bits wide
	localparam int PROD_W = PIX_W + 1 + WGT_W;
	localparam int ACC_W  = 18;

	logic signed [PROD_W-1:0] prod [TAPS];
	logic signed [ACC_W-1:0]  acc;

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			prod[k] = PROD_W'($signed({1'b0, nbhd[k]}))
				* PROD_W'($signed(weights[k*WGT_W +: WGT_W]));
		end
	end

	always_comb begin
		acc = ACC_W'($signed({1'b0, offset}));
		for (int k = 0; k < TAPS; k++) begin
			acc = acc + ACC_W'(prod[k]);
		end
	end

	always_comb begin
		if (acc < 0) begin
			result = '0;
		end else if (acc > ACC_W'(255)) begin
			result = '1;
		end else begin
			result = acc[PIX_W-1:0];
		end
	end

endmodule

// File: rtl/core/sharpen_3x3_convolution_core.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_convolution_core
// 3x3 weighted-sum sharpen filter over a raster-order grayscale stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_stall in raster order, one transfer each.
//   Every pixel that completes an interior 3x3 window yields one transfer on
//   out_valid/out_stall carrying the filtered centre pixel, its row and
//   column and a frame_done flag on the last interior pixel of the frame.
//   Border pixels produce nothing.
//   Throughput: one pixel per clock while out_stall does not hold it; the
//   window, the line store read and the nine-tap sum all run once per pixel
//   in a single pass between the stage register and the output register.
//   Stalls: while out_stall holds a pending result, the stage register
//   moves on only if the output register frees up; otherwise in_stall
//   rises in the same cycle.
//   Reset: config returns to 200x200, offset 128, sharpen weights; row and
//   column counters and the window clear. The line store is not cleared;
//   unwritten entries feed only border pixels. Configuration (cfg_valid/
//   cfg_ready, always ready) must be written while idle; it is not checked.
// ----------------------------------------------------------------------------
module sharpen_3x3_convolution_core import sharp_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      in_pixel,
	// filtered output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      out_pixel,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_col,
	output logic                  frame_done,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ---------------- configuration registers ----------------
	logic [IMGW_W-1:0] image_width_q;
	logic [IMGH_W-1:0] image_height_q;
	logic [OFS_W-1:0]  output_offset_q;
	logic [KERN_W-1:0] kernel_weights_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= WIDTH_RST;
			image_height_q   <= HEIGHT_RST;
			output_offset_q  <= OFFSET_RST;
			kernel_weights_q <= WEIGHTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:   image_width_q    <= cfg_data[IMGW_W-1:0];
				CFG_HEIGHT:  image_height_q   <= cfg_data[IMGH_W-1:0];
				CFG_OFFSET:  output_offset_q  <= cfg_data[OFS_W-1:0];
				CFG_WEIGHTS: kernel_weights_q <= cfg_data[KERN_W-1:0];
				default: ;
			endcase
		end
	end

	// active geometry, clamped to what the hardware supports
	logic [COL_W:0]    act_w;
	logic [IMGH_W-1:0] act_h;

	always_comb begin
		if (image_width_q < IMGW_W'(GEOM_MIN)) begin
			act_w = (COL_W+1)'(GEOM_MIN);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			act_w = (COL_W+1)'(MAX_WIDTH);
		end else begin
			act_w = (COL_W+1)'(image_width_q);
		end
	end

	always_comb begin
		if (image_height_q < IMGH_W'(GEOM_MIN)) begin
			act_h = IMGH_W'(GEOM_MIN);
		end else if (image_height_q > IMGH_W'(HEIGHT_MAX)) begin
			act_h = IMGH_W'(HEIGHT_MAX);
		end else begin
			act_h = image_height_q;
		end
	end

	// ---------------- handshake ----------------
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;
	logic in_accept;

	// the stage register drains whenever the output register is free or leaving
	assign s1_adv    = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	// ---------------- raster counters ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             col_wrap;
	logic             row_wrap;
	logic             interior;
	logic             last_pix;

	assign col_wrap = ({1'b0, col_q} + (COL_W+1)'(1)) >= act_w;
	assign row_wrap = ({1'b0, row_q} + IMGH_W'(1)) >= act_h;
	assign interior = (col_q >= COL_W'(2)) && ({1'b0, col_q} < act_w)
		&& (row_q >= ROW_W'(2)) && ({1'b0, row_q} < act_h);
	assign last_pix = ({1'b0, col_q} == act_w - (COL_W+1)'(1))
		&& ({1'b0, row_q} == act_h - IMGH_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ---------------- stage 1: pixel, position, line store read ----------------
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             emit_s1;
	logic             done_s1;
	line_pair_t       above_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1  <= in_pixel;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= interior;
			done_s1 <= last_pix;
		end
	end

	// read at the incoming column; the item in stage 1 writes its own column
	// back as it leaves, which is never the column being read
	sharp_line_buf #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (col_q),
		.rd_data (above_s1),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data ('{upper: above_s1.middle, middle: pix_s1})
	);

	// ---------------- window: two previous columns, top to bottom ----------------
	pix_t win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= above_s1.upper;
			win_q[4] <= above_s1.middle;
			win_q[5] <= pix_s1;
		end
	end

	nbhd_t nbhd;
	pix_t  filt;

	assign nbhd[0] = win_q[0];
	assign nbhd[1] = win_q[3];
	assign nbhd[2] = above_s1.upper;
	assign nbhd[3] = win_q[1];
	assign nbhd[4] = win_q[4];
	assign nbhd[5] = above_s1.middle;
	assign nbhd[6] = win_q[2];
	assign nbhd[7] = win_q[5];
	assign nbhd[8] = pix_s1;

	sharp_mac u_mac (
		.nbhd    (nbhd),
		.weights (kernel_weights_q),
		.offset  (output_offset_q),
		.result  (filt)
	);

	// ---------------- output register ----------------
	pix_t             out_pixel_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= emit_s1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_pixel_q  <= filt;
			out_row_q    <= row_s1 - ROW_W'(1);
			out_col_q    <= col_s1 - COL_W'(1);
			frame_done_q <= done_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_done = frame_done_q;

`ifndef SYNTH
	// a transfer in always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> s1_valid_q)
		else $error("accepted pixel did not reach stage 1");

	// column counter stays inside the line store
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < MAX_WIDTH)
		else $error("column counter past line store depth");

	// line store write back never hits the column being read
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && in_accept) |-> (col_s1 != col_q))
		else $error("line store read and write at the same column");

	// results are interior only
	a_out_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_row_q != '0) && (out_col_q != '0))
		else $error("result on a border position");
`endif

endmodule
